[design/unique_value_set_table_top_defines.svh]
// assertion macros for the set membership table
// each macro checks a property at every rising edge of i_clk outside reset
`ifndef UNIQUE_VALUE_SET_TABLE_TOP_DEFINES_SVH
`define UNIQUE_VALUE_SET_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define UVST_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("uvst check failed");
// antecedent implies consequent in the next cycle
`define UVST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("uvst check failed");
`else
`define UVST_ASSERT_SAME(lbl, ante, cons)
`define UVST_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[design/uvst_pkg.sv]
`timescale 1ns / 1ps

package uvst_pkg;

    // set size and stored value width
    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;

    // port field widths
    localparam int ELEM_W      = 32;
    localparam int MODE_W      = 2;
    localparam int COUNT_OUT_W = 5;
    localparam int OUT_W       = 8;

    // derived storage widths
    localparam int VAL_W  = (VALUE_WIDTH < ELEM_W) ? VALUE_WIDTH : ELEM_W;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic search;
        logic shift;
        logic append;
        logic refuse;
        logic dec;
        logic finish;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic hit;
        logic miss;
        logic shift_done;
        logic full;
        logic out_free;
        logic is_insert;
        logic is_remove;
    } t_dp_sts;

endpackage

[design/unique_value_set_table_top.sv]
`timescale 1ns / 1ps
// Set membership table holding up to 16 distinct 32-bit values in a memory with
// one write port and one registered read port. Each item (tuser = mode: 0 insert,
// 1 remove, 2 or 3 query) is looked up by a linear scan of the stored entries, one
// memory read a cycle. A match ends the scan early; a miss scans every stored
// entry. A remove that matches then moves the later entries down one place. The
// block works on one item at a time; the result sits in an output register, so
// the next item is taken while the previous result waits. An item whose result
// is ready waits in its final state until that register is free.

`include "unique_value_set_table_top_defines.svh"

module unique_value_set_table_top
    import uvst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // element[31:0]
    input  logic [ELEM_W-1:0] i_s_axis_tdata,
    // mode[1:0]
    input  logic [MODE_W-1:0] i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // was_present[0], entry_count[5:1], set_empty[6], insert_refused[7]
    output logic [OUT_W-1:0]  o_m_axis_tdata
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencer
    uvst_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (w_sts),
        .o_cmd           (w_cmd)
    );

    // store, scan and result register
    uvst_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_element       (i_s_axis_tdata),
        .i_mode          (i_s_axis_tuser),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // checks
    `UVST_ASSERT_SAME(a_append_not_full, w_cmd.append, !w_sts.full && !w_cmd.refuse)
    `UVST_ASSERT_SAME(a_finish_out_free, w_cmd.finish, w_sts.out_free)
    `UVST_ASSERT_NEXT(a_busy_after_load, w_cmd.load, !o_s_axis_tready)

endmodule

[design/uvst_ram.sv]
`timescale 1ns / 1ps

module uvst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                             i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                             o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/uvst_ctrl.sv]
`timescale 1ns / 1ps

module uvst_ctrl
    import uvst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_axis_tvalid,
    output logic    o_s_axis_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_sts.hit) begin
                    n_state = i_sts.is_remove ? S_SHIFT : S_FINISH;
                end else if (i_sts.miss) begin
                    if (i_sts.is_insert) begin
                        o_cmd.refuse = i_sts.full;
                        o_cmd.append = !i_sts.full;
                    end
                    n_state = S_FINISH;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_sts.shift_done) begin
                    o_cmd.dec = 1'b1;
                    n_state   = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);

endmodule

[design/uvst_dpath.sv]
`timescale 1ns / 1ps

module uvst_dpath
    import uvst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [ELEM_W-1:0] i_element,
    input  logic [MODE_W-1:0] i_mode,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    input  logic             i_m_axis_tready,
    output logic             o_m_axis_tvalid,
    output logic [OUT_W-1:0] o_m_axis_tdata
);

    logic [MODE_W-1:0]   r_mode;
    logic [VAL_W-1:0]    r_elem;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_ptr;
    logic                r_pend_vld;
    logic [ADDR_W-1:0]   r_pend_idx;
    logic                r_hit;
    logic                r_refused;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;

    logic [VAL_W-1:0]    w_rdata;
    logic                w_match;
    logic                w_issue;
    logic                w_wr_en;
    logic [ADDR_W-1:0]   w_wr_addr;
    logic [VAL_W-1:0]    w_wr_data;
    logic [CNT_W+COUNT_OUT_W-1:0] w_count_ext;
    logic [OUT_W-1:0]    w_result;

    // entry store
    uvst_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (r_ptr[ADDR_W-1:0]),
        .o_rd_data (w_rdata)
    );

    // compare, write port steering and result packing
    always_comb begin
        w_match     = r_pend_vld && (w_rdata == r_elem);
        w_issue     = (r_ptr < r_count);
        w_wr_en     = i_cmd.append || (i_cmd.shift && r_pend_vld);
        w_wr_addr   = i_cmd.append ? r_count[ADDR_W-1:0] : (r_pend_idx - ADDR_W'(1));
        w_wr_data   = i_cmd.append ? r_elem : w_rdata;
        w_count_ext = {{COUNT_OUT_W{1'b0}}, r_count};
        w_result    = {r_refused, (r_count == '0), w_count_ext[COUNT_OUT_W-1:0], r_hit};
    end

    // status to controller
    always_comb begin
        o_sts.hit        = w_match;
        o_sts.miss       = !w_match && (r_ptr == r_count);
        o_sts.shift_done = !r_pend_vld && !w_issue;
        o_sts.full       = (r_count >= CNT_W'(CAPACITY));
        o_sts.out_free   = !r_out_valid || i_m_axis_tready;
        o_sts.is_insert  = (r_mode == MODE_INSERT);
        o_sts.is_remove  = (r_mode == MODE_REMOVE);
    end

    // item registers and scan pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode     <= i_mode;
            r_elem     <= i_element[VAL_W-1:0];
            r_hit      <= 1'b0;
            r_refused  <= 1'b0;
            r_ptr      <= '0;
            r_pend_idx <= '0;
        end else if (i_cmd.search && w_match) begin
            r_hit <= 1'b1;
            r_ptr <= CNT_W'(r_pend_idx) + CNT_W'(1);
        end else if ((i_cmd.search || i_cmd.shift) && w_issue) begin
            r_pend_idx <= r_ptr[ADDR_W-1:0];
            r_ptr      <= r_ptr + CNT_W'(1);
        end
        if (i_cmd.refuse) begin
            r_refused <= 1'b1;
        end
    end

    // read pending flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
        end else if (i_cmd.load || (i_cmd.search && w_match)) begin
            r_pend_vld <= 1'b0;
        end else if (i_cmd.search || i_cmd.shift) begin
            r_pend_vld <= w_issue;
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.append) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.dec) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_data <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
